// ===== design/perlin_gradient_noise_turbulence_core_assert.svh =====
// Shared assertion macros for the noise core.
`ifndef PERLIN_GRADIENT_NOISE_TURBULENCE_CORE_ASSERT_SVH
`define PERLIN_GRADIENT_NOISE_TURBULENCE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PGNT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PGNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pgnt_pkg.sv =====
package pgnt_pkg;

    // Request codes
    typedef enum logic [2:0] {
        REQ_EVAL   = 3'd0,
        REQ_PERM_X = 3'd1,
        REQ_PERM_Y = 3'd2,
        REQ_PERM_Z = 3'd3,
        REQ_GRAD   = 3'd4
    } t_req_type;

    localparam int OCT_W   = 4;
    localparam int FRAC_W  = 16;
    localparam int NOISE_W = 22;
    localparam int OUT_W   = 18;

    localparam logic [OCT_W-1:0]          OCT_COUNT_RST = 4'd7;
    localparam logic [FRAC_W:0]           ONE_Q16       = 17'h10000;
    localparam logic signed [NOISE_W-1:0] NOISE_HI      = 22'sd131071;
    localparam logic signed [NOISE_W-1:0] NOISE_LO      = -22'sd131072;
    localparam logic [OUT_W-1:0]          TURB_MAX      = 18'h3FFFF;

    // One octave job issued into the evaluation pipeline
    typedef struct packed {
        logic                vld;
        t_req_type           req;
        logic [7:0]          idx;
        logic [7:0]          perm;
        logic signed [15:0]  grad_x;
        logic signed [15:0]  grad_y;
        logic signed [15:0]  grad_z;
        logic [31:0]         pt_x;
        logic [31:0]         pt_y;
        logic [31:0]         pt_z;
        logic [OCT_W-1:0]    k;
        logic                first;
        logic                last;
    } t_job;

    // Octave bookkeeping that rides with the data
    typedef struct packed {
        logic             vld;
        logic [OCT_W-1:0] k;
        logic             first;
        logic             last;
    } t_tag;

    typedef struct packed {
        t_tag                       tag;
        logic signed [NOISE_W-1:0]  noise;
    } t_octave;

endpackage

// ===== design/perlin_gradient_noise_turbulence_core.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_req_type .. i_point_z
// result    out        o_valid / i_stall         o_noise_value, o_turbulence_value
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (octave count)
//
// An evaluate transaction issues its octaves (1..MAX_OCTAVES) in turn from the issue
// stage as the pipeline advances; a load issues once; unknown requests are dropped.
// The last octave passes the eval stages and accumulator into the result register.
// Reset is synchronous, active low; it clears control state, tables stay undefined.
// A held result freezes every stage; nothing is lost or repeated.
module perlin_gradient_noise_turbulence_core
    import pgnt_pkg::*;
#(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_req_type,
    input  logic [7:0]              i_table_index,
    input  logic [7:0]              i_perm_entry,
    input  logic signed [15:0]      i_grad_x,
    input  logic signed [15:0]      i_grad_y,
    input  logic signed [15:0]      i_grad_z,
    input  logic signed [31:0]      i_point_x,
    input  logic signed [31:0]      i_point_y,
    input  logic signed [31:0]      i_point_z,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_noise_value,
    output logic [OUT_W-1:0]        o_turbulence_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [OCT_W-1:0]        i_cfg_data
);

    logic [OCT_W-1:0] r_octave_count;
    logic             w_adv;
    t_job             w_job;
    t_octave          w_oct;

    // Octave count register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCT_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_octave_count <= i_cfg_data;
        end
    end

    pgnt_seq #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_table_index (i_table_index),
        .i_perm_entry  (i_perm_entry),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_grad_z      (i_grad_z),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_octave_count(r_octave_count),
        .i_adv         (w_adv),
        .o_job         (w_job)
    );

    pgnt_eval #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_eval (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_job  (w_job),
        .o_oct  (w_oct)
    );

    pgnt_accum #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_oct             (w_oct),
        .i_stall           (i_stall),
        .o_adv             (w_adv),
        .o_valid           (o_valid),
        .o_noise_value     (o_noise_value),
        .o_turbulence_value(o_turbulence_value)
    );

endmodule

// ===== design/pgnt_ram.sv =====
module pgnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pgnt_seq.sv =====
`include "perlin_gradient_noise_turbulence_core_assert.svh"

module pgnt_seq
    import pgnt_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_req_type,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_perm_entry,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [OCT_W-1:0]   i_octave_count,
    input  logic               i_adv,
    output t_job               o_job
);

    logic               r_busy;
    logic [OCT_W-1:0]   r_k;
    logic [OCT_W-1:0]   r_last_k;
    t_req_type          r_req;
    logic [7:0]         r_idx;
    logic [7:0]         r_perm;
    logic signed [15:0] r_gx, r_gy, r_gz;
    logic [31:0]        r_px, r_py, r_pz;

    logic               w_accept;
    logic               w_last;
    logic               w_is_eval;
    logic               w_is_load;
    logic [OCT_W:0]     w_oct;
    t_req_type          w_req;

    assign w_req     = t_req_type'(i_req_type);
    assign w_is_eval = (w_req == REQ_EVAL);
    assign w_is_load = (w_req inside {REQ_PERM_X, REQ_PERM_Y, REQ_PERM_Z, REQ_GRAD});
    assign w_last    = (r_k == r_last_k);
    assign o_stall   = !i_adv || (r_busy && !w_last);
    assign w_accept  = i_valid && !o_stall;

    // Clamp the octave count into 1..MAX_OCTAVES
    always_comb begin
        w_oct = {1'b0, i_octave_count};
        if (w_oct == '0) begin
            w_oct = (OCT_W+1)'(1);
        end else if (w_oct > (OCT_W+1)'(MAX_OCTAVES)) begin
            w_oct = (OCT_W+1)'(MAX_OCTAVES);
        end
    end

    // Issue control: one octave per advancing cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_k      <= '0;
            r_last_k <= '0;
        end else if (i_adv) begin
            if (w_accept) begin
                r_busy   <= w_is_eval || w_is_load;
                r_k      <= '0;
                r_last_k <= w_is_eval ? OCT_W'(w_oct - (OCT_W+1)'(1)) : '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + OCT_W'(1);
                end
            end
        end
    end

    // Hold the transaction payload for all of its octaves
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= w_req;
            r_idx  <= i_table_index;
            r_perm <= i_perm_entry;
            r_gx   <= i_grad_x;
            r_gy   <= i_grad_y;
            r_gz   <= i_grad_z;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
        end
    end

    // Octave k samples the point scaled by 2^k
    always_comb begin
        o_job.vld    = r_busy;
        o_job.req    = r_req;
        o_job.idx    = r_idx;
        o_job.perm   = r_perm;
        o_job.grad_x = r_gx;
        o_job.grad_y = r_gy;
        o_job.grad_z = r_gz;
        o_job.pt_x   = r_px << r_k;
        o_job.pt_y   = r_py << r_k;
        o_job.pt_z   = r_pz << r_k;
        o_job.k      = r_k;
        o_job.first  = (r_k == '0);
        o_job.last   = w_last;
    end

    `PGNT_ASSERT_NOW(a_k_in_range, i_clk, i_rst_n, r_busy, r_k <= r_last_k, "octave index past count")
    `PGNT_ASSERT_NEXT(a_busy_holds, i_clk, i_rst_n, r_busy && i_adv && !w_last, r_busy, "issue ended early")

endmodule

// ===== design/pgnt_eval.sv =====
module pgnt_eval
    import pgnt_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_job    i_job,
    output t_octave o_oct
);

    localparam int TBITS = $clog2(TABLE_SIZE);
    localparam t_req_type PERM_REQ [3] = '{REQ_PERM_X, REQ_PERM_Y, REQ_PERM_Z};

    // Stage 0: split the point, address the permutation stores
    logic [FRAC_W-1:0] w0_u  [3];
    logic [TBITS-1:0]  w0_b  [3];
    logic [31:0]       w0_pt [3];
    logic [31:0]       w0_u2 [3];
    logic [17:0]       w0_t  [3];
    logic [7:0]        w1_perm [3][2];
    t_tag              w0_tag;

    assign w0_pt[0] = i_job.pt_x;
    assign w0_pt[1] = i_job.pt_y;
    assign w0_pt[2] = i_job.pt_z;

    always_comb begin
        w0_tag.vld   = i_job.vld && (i_job.req == REQ_EVAL);
        w0_tag.k     = i_job.k;
        w0_tag.first = i_job.first;
        w0_tag.last  = i_job.last;
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis0
        assign w0_u[a]  = w0_pt[a][FRAC_W-1:0];
        assign w0_b[a]  = w0_pt[a][FRAC_W +: TBITS];
        assign w0_u2[a] = {16'b0, w0_u[a]} * {16'b0, w0_u[a]};
        assign w0_t[a]  = 18'd196608 - {1'b0, w0_u[a], 1'b0};
        for (genvar e = 0; e < 2; e++) begin : g_perm
            pgnt_ram #(
                .WIDTH(8),
                .DEPTH(TABLE_SIZE)
            ) u_perm (
                .i_clk  (i_clk),
                .i_we   (i_adv && i_job.vld && (i_job.req == PERM_REQ[a])),
                .i_waddr(TBITS'(i_job.idx)),
                .i_wdata(i_job.perm),
                .i_re   (i_adv),
                .i_raddr(w0_b[a] + TBITS'(e)),
                .o_rdata(w1_perm[a][e])
            );
        end
    end

    // Stage 1 registers
    t_tag              r1_tag;
    logic              r1_grad_we;
    logic [7:0]        r1_idx;
    logic [47:0]       r1_grad;
    logic [FRAC_W-1:0] r1_u  [3];
    logic [31:0]       r1_u2 [3];
    logic [17:0]       r1_t  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag     <= '0;
            r1_grad_we <= 1'b0;
        end else if (i_adv) begin
            r1_tag     <= w0_tag;
            r1_grad_we <= i_job.vld && (i_job.req == REQ_GRAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_idx  <= i_job.idx;
            r1_grad <= {i_job.grad_x, i_job.grad_y, i_job.grad_z};
            r1_u    <= w0_u;
            r1_u2   <= w0_u2;
            r1_t    <= w0_t;
        end
    end

    // Stage 1: hash the corners, read gradients, finish smoothstep
    logic [TBITS-1:0]  w1_h    [8];
    logic [47:0]       w2_grad [8];
    logic [49:0]       w1_sp   [3];
    logic [FRAC_W:0]   w1_s    [3];

    for (genvar c = 0; c < 8; c++) begin : g_corner1
        localparam int BI = (c >> 2) & 1;
        localparam int BJ = (c >> 1) & 1;
        localparam int BK = c & 1;
        assign w1_h[c] = TBITS'(w1_perm[0][BI] ^ w1_perm[1][BJ] ^ w1_perm[2][BK]);
        pgnt_ram #(
            .WIDTH(48),
            .DEPTH(TABLE_SIZE)
        ) u_grad (
            .i_clk  (i_clk),
            .i_we   (i_adv && r1_grad_we),
            .i_waddr(TBITS'(r1_idx)),
            .i_wdata(r1_grad),
            .i_re   (i_adv),
            .i_raddr(w1_h[c]),
            .o_rdata(w2_grad[c])
        );
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis1
        assign w1_sp[a] = 50'(r1_u2[a]) * 50'(r1_t[a]);
        assign w1_s[a]  = w1_sp[a][48:32];
    end

    // Stage 2 registers
    t_tag              r2_tag;
    logic [FRAC_W:0]   r2_s [3];
    logic [FRAC_W-1:0] r2_u [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (i_adv) begin
            r2_tag <= r1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_s <= w1_s;
            r2_u <= r1_u;
        end
    end

    // Stage 2: offset products and the xy weights
    logic signed [17:0] w2_off [3][2];
    logic [FRAC_W:0]    w2_w   [3][2];
    logic signed [31:0] w2_dp  [8][3];
    logic [33:0]        w2_pxy [2][2];
    logic [FRAC_W:0]    w2_wxy [2][2];

    for (genvar a = 0; a < 3; a++) begin : g_axis2
        assign w2_off[a][0] = $signed({2'b00, r2_u[a]});
        assign w2_off[a][1] = $signed({2'b00, r2_u[a]}) - 18'sd65536;
        assign w2_w[a][0]   = ONE_Q16 - r2_s[a];
        assign w2_w[a][1]   = r2_s[a];
    end

    for (genvar c = 0; c < 8; c++) begin : g_corner2
        localparam int BI = (c >> 2) & 1;
        localparam int BJ = (c >> 1) & 1;
        localparam int BK = c & 1;
        assign w2_dp[c][0] = 32'($signed(w2_grad[c][47:32]) * w2_off[0][BI]);
        assign w2_dp[c][1] = 32'($signed(w2_grad[c][31:16]) * w2_off[1][BJ]);
        assign w2_dp[c][2] = 32'($signed(w2_grad[c][15:0])  * w2_off[2][BK]);
    end

    for (genvar i = 0; i < 2; i++) begin : g_wx
        for (genvar j = 0; j < 2; j++) begin : g_wy
            assign w2_pxy[i][j] = 34'(w2_w[0][i]) * 34'(w2_w[1][j]);
            assign w2_wxy[i][j] = w2_pxy[i][j][32:16];
        end
    end

    // Stage 3 registers
    t_tag               r3_tag;
    logic signed [31:0] r3_dp  [8][3];
    logic [FRAC_W:0]    r3_wxy [2][2];
    logic [FRAC_W:0]    r3_wz  [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else if (i_adv) begin
            r3_tag <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_dp  <= w2_dp;
            r3_wxy <= w2_wxy;
            r3_wz  <= w2_w[2];
        end
    end

    // Stage 3: dot products and full corner weights
    logic signed [33:0] w3_dot [8];
    logic [33:0]        w3_pw  [8];
    logic [FRAC_W:0]    w3_w   [8];

    for (genvar c = 0; c < 8; c++) begin : g_corner3
        localparam int BI = (c >> 2) & 1;
        localparam int BJ = (c >> 1) & 1;
        localparam int BK = c & 1;
        assign w3_dot[c] = 34'(r3_dp[c][0]) + 34'(r3_dp[c][1]) + 34'(r3_dp[c][2]);
        assign w3_pw[c]  = 34'(r3_wxy[BI][BJ]) * 34'(r3_wz[BK]);
        assign w3_w[c]   = w3_pw[c][32:16];
    end

    // Stage 4 registers
    t_tag               r4_tag;
    logic signed [33:0] r4_dot [8];
    logic [FRAC_W:0]    r4_w   [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
        end else if (i_adv) begin
            r4_tag <= r3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_dot <= w3_dot;
            r4_w   <= w3_w;
        end
    end

    // Stage 4: weight each corner
    logic signed [51:0] w4_wd [8];

    for (genvar c = 0; c < 8; c++) begin : g_corner4
        assign w4_wd[c] = $signed({1'b0, r4_w[c]}) * r4_dot[c];
    end

    // Stage 5 registers
    t_tag               r5_tag;
    logic signed [51:0] r5_wd [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_tag <= '0;
        end else if (i_adv) begin
            r5_tag <= r4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_wd <= w4_wd;
        end
    end

    // Stage 5: first level of the corner sum
    logic signed [52:0] w5_ps [4];

    for (genvar i = 0; i < 4; i++) begin : g_pair
        assign w5_ps[i] = 53'(r5_wd[2*i]) + 53'(r5_wd[2*i+1]);
    end

    // Stage 6 registers
    t_tag               r6_tag;
    logic signed [52:0] r6_ps [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_tag <= '0;
        end else if (i_adv) begin
            r6_tag <= r5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_ps <= w5_ps;
        end
    end

    // Stage 6: final sum, drop 30 fraction bits (floor)
    logic signed [54:0] w6_tot;

    assign w6_tot = 55'(r6_ps[0]) + 55'(r6_ps[1]) + 55'(r6_ps[2]) + 55'(r6_ps[3]);

    t_tag                      r7_tag;
    logic signed [NOISE_W-1:0] r7_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_tag <= '0;
        end else if (i_adv) begin
            r7_tag <= r6_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r7_noise <= w6_tot[30 +: NOISE_W];
        end
    end

    assign o_oct.tag   = r7_tag;
    assign o_oct.noise = r7_noise;

endmodule

// ===== design/pgnt_accum.sv =====
`include "perlin_gradient_noise_turbulence_core_assert.svh"

module pgnt_accum
    import pgnt_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_octave                 i_oct,
    input  logic                    i_stall,
    output logic                    o_adv,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_noise_value,
    output logic [OUT_W-1:0]        o_turbulence_value
);

    localparam int ACC_W = NOISE_W + MAX_OCTAVES + $clog2(MAX_OCTAVES) + 1;

    logic                      r_fin_vld;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [NOISE_W-1:0] r_n0;
    logic                      r_out_vld;
    logic signed [OUT_W-1:0]   r_noise;
    logic [OUT_W-1:0]          r_turb;

    logic [OCT_W-1:0]          w_sh;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   w_base;
    logic [ACC_W-1:0]          w_mag;
    logic [ACC_W-1:0]          w_t;
    logic signed [OUT_W-1:0]   w_noise;
    logic [OUT_W-1:0]          w_turb;

    // Advance the whole pipeline unless the result register is held
    assign o_adv = !r_out_vld || !i_stall;

    // Octave k carries weight 2^(MAX_OCTAVES-1-k)
    assign w_sh   = OCT_W'(MAX_OCTAVES - 1) - i_oct.tag.k;
    assign w_term = ACC_W'(i_oct.noise) <<< w_sh;
    assign w_base = i_oct.tag.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (o_adv) begin
            r_fin_vld <= i_oct.tag.vld && i_oct.tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_oct.tag.vld) begin
            r_acc <= w_base + w_term;
            if (i_oct.tag.first) begin
                r_n0 <= i_oct.noise;
            end
        end
    end

    // Magnitude, rescale and saturate
    always_comb begin
        w_mag = (r_acc < 0) ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        w_t   = w_mag >> (MAX_OCTAVES - 1);
        if (w_t > ACC_W'(TURB_MAX)) begin
            w_turb = TURB_MAX;
        end else begin
            w_turb = w_t[OUT_W-1:0];
        end
        if (r_n0 > NOISE_HI) begin
            w_noise = OUT_W'(NOISE_HI);
        end else if (r_n0 < NOISE_LO) begin
            w_noise = OUT_W'(NOISE_LO);
        end else begin
            w_noise = OUT_W'(r_n0);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= r_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_fin_vld) begin
            r_noise <= w_noise;
            r_turb  <= w_turb;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_noise_value      = r_noise;
    assign o_turbulence_value = r_turb;

    `PGNT_ASSERT_NOW(a_first_is_k0, i_clk, i_rst_n, i_oct.tag.vld && i_oct.tag.first, i_oct.tag.k == '0, "first octave not k0")
    `PGNT_ASSERT_NEXT(a_fin_to_out, i_clk, i_rst_n, r_fin_vld && o_adv, o_valid, "finished sum not presented")

endmodule

// ===== verif/perlin_gradient_noise_turbulence_core_tb.sv =====
module perlin_gradient_noise_turbulence_core_tb;
    import pgnt_pkg::*;

    localparam int TBL      = 256;
    localparam int OCT_MAX  = 8;
    localparam int GAP_MAX  = 18;
    localparam int SETTLE   = 32;
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]         req;
        logic [7:0]         idx;
        logic [7:0]         perm;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
    } noise_req_t;

    typedef struct {
        logic signed [OUT_W-1:0] noise;
        logic [OUT_W-1:0]        turb;
    } noise_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [2:0]              i_req_type = '0;
    logic [7:0]              i_table_index = '0;
    logic [7:0]              i_perm_entry = '0;
    logic signed [15:0]      i_grad_x = '0;
    logic signed [15:0]      i_grad_y = '0;
    logic signed [15:0]      i_grad_z = '0;
    logic signed [31:0]      i_point_x = '0;
    logic signed [31:0]      i_point_y = '0;
    logic signed [31:0]      i_point_z = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_noise_value;
    logic [OUT_W-1:0]        o_turbulence_value;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [OCT_W-1:0]        i_cfg_data = '0;

    // Shadow tables and register
    logic [7:0]         perm_x_shadow [TBL];
    logic [7:0]         perm_y_shadow [TBL];
    logic [7:0]         perm_z_shadow [TBL];
    logic signed [15:0] grad_shadow   [TBL][3];
    logic [OCT_W-1:0]   octaves_shadow = OCT_COUNT_RST;

    noise_result_t noise_expected [$];
    int            err_count = 0;
    bit            no_idle = 1'b0;

    perlin_gradient_noise_turbulence_core u_dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("perlin_gradient_noise_turbulence_core regression: fail");
        $finish;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Hermite smoothstep in Q0.16
    function automatic longint smoothstep(longint u);
        longint unsigned u2, t;
        u2 = u * u;
        t  = 3 * 65536 - 2 * u;
        return longint'((u2 * t) >> 32);
    endfunction

    // One octave of gradient noise, unsaturated Q.16
    function automatic longint octave_noise(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz);
        logic [31:0] pt [3];
        longint      fu [3];
        longint      sm [3];
        logic [7:0]  lat [3];
        longint      total, dot, wx, wy, wz, w, ox, oy, oz;
        logic [7:0]  h;
        bit          bi, bj, bk;
        pt[0] = px; pt[1] = py; pt[2] = pz;
        total = 0;
        for (int a = 0; a < 3; a++) begin
            fu[a]  = longint'(pt[a][15:0]);
            lat[a] = pt[a][23:16];
            sm[a]  = smoothstep(fu[a]);
        end
        for (int c = 0; c < 8; c++) begin
            bi = c[2]; bj = c[1]; bk = c[0];
            h  = perm_x_shadow[8'(lat[0] + bi)] ^ perm_y_shadow[8'(lat[1] + bj)]
               ^ perm_z_shadow[8'(lat[2] + bk)];
            ox  = fu[0] - (bi ? 65536 : 0);
            oy  = fu[1] - (bj ? 65536 : 0);
            oz  = fu[2] - (bk ? 65536 : 0);
            dot = longint'(grad_shadow[h][0]) * ox + longint'(grad_shadow[h][1]) * oy
                + longint'(grad_shadow[h][2]) * oz;
            wx  = bi ? sm[0] : 65536 - sm[0];
            wy  = bj ? sm[1] : 65536 - sm[1];
            wz  = bk ? sm[2] : 65536 - sm[2];
            w   = (((wx * wy) >>> 16) * wz) >>> 16;
            total += w * dot;
        end
        return total >>> 30;
    endfunction

    // Apply one accepted transaction to the shadow state; queue a result for evaluates
    function automatic void predict_turbulence(noise_req_t it);
        longint        n, n0, acc;
        int            oct;
        noise_result_t r;
        n0 = 0; acc = 0;
        case (it.req)
            REQ_PERM_X: perm_x_shadow[it.idx] = it.perm;
            REQ_PERM_Y: perm_y_shadow[it.idx] = it.perm;
            REQ_PERM_Z: perm_z_shadow[it.idx] = it.perm;
            REQ_GRAD: begin
                grad_shadow[it.idx][0] = it.gx;
                grad_shadow[it.idx][1] = it.gy;
                grad_shadow[it.idx][2] = it.gz;
            end
            REQ_EVAL: begin
                oct = octaves_shadow;
                if (oct < 1) oct = 1;
                if (oct > OCT_MAX) oct = OCT_MAX;
                for (int k = 0; k < oct; k++) begin
                    n = octave_noise(it.x << k, it.y << k, it.z << k);
                    if (k == 0) n0 = n;
                    acc += n * (longint'(1) << (OCT_MAX - 1 - k));
                end
                if (acc < 0) acc = -acc;
                acc = acc >> (OCT_MAX - 1);
                if (acc > 262143) acc = 262143;
                if (n0 > 131071) n0 = 131071;
                if (n0 < -131072) n0 = -131072;
                r.noise = n0[OUT_W-1:0];
                r.turb  = acc[OUT_W-1:0];
                noise_expected.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Send one transaction; valid stays high afterwards until the next send or idle
    task automatic send_req(noise_req_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= it.req;
        i_table_index <= it.idx;
        i_perm_entry  <= it.perm;
        i_grad_x      <= it.gx;
        i_grad_y      <= it.gy;
        i_grad_z      <= it.gz;
        i_point_x     <= it.x;
        i_point_y     <= it.y;
        i_point_z     <= it.z;
        do @(posedge i_clk); while (o_stall);
        predict_turbulence(it);
    endtask

    // Drop valid and wait until the block has drained
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (noise_expected.size() != 0) begin
            @(posedge i_clk);
            guard++;
            if (guard > 50000) begin
                $display("perlin_gradient_noise_turbulence_core regression: fail");
                $finish;
            end
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_octaves(logic [OCT_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        octaves_shadow = v;
    endtask

    function automatic logic signed [15:0] rand_grad();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic noise_req_t eval_req(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
        noise_req_t it;
        it = '{default: '0};
        it.req = REQ_EVAL;
        it.x = x; it.y = y; it.z = z;
        return it;
    endfunction

    function automatic noise_req_t rand_req();
        noise_req_t it;
        int         pick;
        it.idx  = 8'($urandom);
        it.perm = 8'($urandom);
        it.gx   = rand_grad();
        it.gy   = rand_grad();
        it.gz   = rand_grad();
        it.x    = $urandom;
        it.y    = $urandom;
        it.z    = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 70)      it.req = REQ_EVAL;
        else if (pick < 76) it.req = REQ_PERM_X;
        else if (pick < 82) it.req = REQ_PERM_Y;
        else if (pick < 88) it.req = REQ_PERM_Z;
        else if (pick < 95) it.req = REQ_GRAD;
        else                it.req = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        return it;
    endfunction

    // Fill every table entry so no evaluate reads an unwritten one
    task automatic test_table_fill();
        noise_req_t it;
        no_idle = 1'b1;
        for (int i = 0; i < TBL; i++) begin
            it = rand_req();
            it.idx = 8'(i);
            it.req = REQ_PERM_X; it.perm = (i == 0) ? 8'd255 : 8'($urandom); send_req(it);
            it.req = REQ_PERM_Y; it.perm = (i == 1) ? 8'd0 : 8'($urandom);   send_req(it);
            it.req = REQ_PERM_Z; it.perm = 8'($urandom);                     send_req(it);
            it.req = REQ_GRAD;
            if (i == 0) begin
                it.gx = 16'sd16384; it.gy = -16'sd16384; it.gz = 16'sd16384;
            end else if (i == 255) begin
                it.gx = -16'sd16384; it.gy = 16'sd16384; it.gz = -16'sd16384;
            end
            send_req(it);
        end
        no_idle = 1'b0;
    endtask

    // Point extremes, unknown requests and the last table index
    task automatic test_directed_points();
        noise_req_t it;
        send_req(eval_req(32'h0, 32'h0, 32'h0));
        send_req(eval_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_req(eval_req(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000));
        send_req(eval_req(32'h00FF_FFFF, 32'h00FF_8000, 32'h0000_FFFF));
        send_req(eval_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
        for (logic [2:0] r = REQ_BAD_LO; ; r++) begin
            it = rand_req();
            it.req = r;
            send_req(it);
            if (r == REQ_BAD_HI) break;
        end
        it = rand_req();
        it.req = REQ_GRAD; it.idx = 8'd255; it.gx = 16'sd0; it.gy = 16'sd16384;
        it.gz = -16'sd16384;
        send_req(it);
        send_req(eval_req(32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF));
    endtask

    // Octave register across its whole range, extremes included
    task automatic test_octave_sweep();
        logic [OCT_W-1:0] vals [6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd4, 4'd9};
        foreach (vals[i]) begin
            set_octaves(vals[i]);
            send_req(eval_req(32'h7FFF_FFFF, 32'h8000_0000, $urandom));
            repeat (3) send_req(eval_req($urandom, $urandom, $urandom));
        end
    endtask

    // Random mix across several octave settings, one burst without idling
    task automatic test_random_mix();
        for (int ph = 0; ph < 7; ph++) begin
            set_octaves(ph == 0 ? 4'd8 : 4'($urandom_range(0, 15)));
            no_idle = (ph == 3);
            repeat (100) send_req(rand_req());
        end
        no_idle = 1'b0;
    endtask

    // Result side stall pattern
    initial begin
        int n;
        forever begin
            n = draw_gap();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        noise_result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (noise_expected.size() == 0) begin
                $error("unexpected result noise=%0d turb=%0d", o_noise_value,
                       o_turbulence_value);
                err_count++;
            end else begin
                e = noise_expected.pop_front();
                if (o_noise_value !== e.noise) begin
                    $error("noise_value expected %0d actual %0d", e.noise, o_noise_value);
                    err_count++;
                end
                if (o_turbulence_value !== e.turb) begin
                    $error("turbulence_value expected %0d actual %0d", e.turb,
                           o_turbulence_value);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_fill();
        test_directed_points();
        test_octave_sweep();
        test_random_mix();
        wait_idle();
        if (err_count == 0 && noise_expected.size() == 0)
            $display("perlin_gradient_noise_turbulence_core regression: pass");
        else
            $display("perlin_gradient_noise_turbulence_core regression: fail");
        $finish;
    end

endmodule

// ===== perlin_gradient_noise_turbulence_core.f =====
+incdir+design
design/pgnt_pkg.sv
design/pgnt_ram.sv
design/pgnt_seq.sv
design/pgnt_eval.sv
design/pgnt_accum.sv
design/perlin_gradient_noise_turbulence_core.sv
verif/perlin_gradient_noise_turbulence_core_tb.sv
